[sv/o2e_pkg.sv]
// Package: shared constants, register indexes and the CORDIC arctangent table.
package o2e_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TRIG_STAGES_DEF = 16;

  localparam int TRIG_FRAC    = 30;
  localparam int CORD_W       = 33;
  localparam int ANG_FULL_W   = 32;
  localparam int CORDIC_INIT  = 652032874;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [1:0] REG_EGO_X       = 2'd0;
  localparam logic [1:0] REG_EGO_Y       = 2'd1;
  localparam logic [1:0] REG_EGO_HEADING = 2'd2;

  localparam logic [1:0] KIND_POSITION = 2'd0;

  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051D;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2E;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      20:      v = 32'h0000028B;
      21:      v = 32'h00000145;
      22:      v = 32'h000000A2;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[sv/o2e_cordic_cell.sv]
// One CORDIC rotation cell: a single micro-rotation, registered, with payload alongside.
module o2e_cordic_cell
  import o2e_pkg::*;
#(
  parameter int STAGE = 0,
  parameter int PAY_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic signed [CORD_W-1:0] z_i,
  input  logic                     flip_i,
  input  logic [PAY_W-1:0]         pay_i,
  output logic                     vld_o,
  output logic signed [CORD_W-1:0] x_o,
  output logic signed [CORD_W-1:0] y_o,
  output logic signed [CORD_W-1:0] z_o,
  output logic                     flip_o,
  output logic [PAY_W-1:0]         pay_o
);

  localparam logic signed [CORD_W-1:0] ATAN = CORD_W'(atan_turn(STAGE));

  logic                     vld_r;
  logic signed [CORD_W-1:0] x_r, y_r, z_r;
  logic signed [CORD_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [CORD_W-1:0] xs, ys;
  logic                     flip_r;
  logic [PAY_W-1:0]         pay_r;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!z_i[CORD_W-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_i;
    pay_r  <= pay_i;
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign flip_o = flip_r;
  assign pay_o  = pay_r;

endmodule

[sv/o2e_root_cell.sv]
// One square-root cell: one result bit of two restoring digit-by-digit roots, registered.
module o2e_root_cell #(
  parameter int RAD_W = 68,
  parameter int PAY_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  logic [RAD_W-1:0]   rad_a_i,
  input  logic [RAD_W/2+1:0] rem_a_i,
  input  logic [RAD_W/2-1:0] root_a_i,
  input  logic [RAD_W-1:0]   rad_b_i,
  input  logic [RAD_W/2+1:0] rem_b_i,
  input  logic [RAD_W/2-1:0] root_b_i,
  input  logic [PAY_W-1:0]   pay_i,
  output logic               vld_o,
  output logic [RAD_W-1:0]   rad_a_o,
  output logic [RAD_W/2+1:0] rem_a_o,
  output logic [RAD_W/2-1:0] root_a_o,
  output logic [RAD_W-1:0]   rad_b_o,
  output logic [RAD_W/2+1:0] rem_b_o,
  output logic [RAD_W/2-1:0] root_b_o,
  output logic [PAY_W-1:0]   pay_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic               vld_r;
  logic [RAD_W-1:0]   rad_a_r, rad_b_r;
  logic [REM_W-1:0]   rem_a_r, rem_b_r, rem_a_nxt, rem_b_nxt;
  logic [ROOT_W-1:0]  root_a_r, root_b_r, root_a_nxt, root_b_nxt;
  logic [REM_W-1:0]   sh_a, sh_b, trial_a, trial_b;
  logic               ge_a, ge_b;
  logic [PAY_W-1:0]   pay_r;

  always_comb begin
    sh_a       = {rem_a_i[REM_W-3:0], rad_a_i[RAD_W-1 -: 2]};
    trial_a    = {root_a_i, 2'b01};
    ge_a       = sh_a >= trial_a;
    rem_a_nxt  = ge_a ? sh_a - trial_a : sh_a;
    root_a_nxt = {root_a_i[ROOT_W-2:0], ge_a};
    sh_b       = {rem_b_i[REM_W-3:0], rad_b_i[RAD_W-1 -: 2]};
    trial_b    = {root_b_i, 2'b01};
    ge_b       = sh_b >= trial_b;
    rem_b_nxt  = ge_b ? sh_b - trial_b : sh_b;
    root_b_nxt = {root_b_i[ROOT_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_a_r  <= {rad_a_i[RAD_W-3:0], 2'b00};
    rem_a_r  <= rem_a_nxt;
    root_a_r <= root_a_nxt;
    rad_b_r  <= {rad_b_i[RAD_W-3:0], 2'b00};
    rem_b_r  <= rem_b_nxt;
    root_b_r <= root_b_nxt;
    pay_r    <= pay_i;
  end

  assign vld_o    = vld_r;
  assign rad_a_o  = rad_a_r;
  assign rem_a_o  = rem_a_r;
  assign root_a_o = root_a_r;
  assign rad_b_o  = rad_b_r;
  assign rem_b_o  = rem_b_r;
  assign root_b_o = root_b_r;
  assign pay_o    = pay_r;

endmodule

[sv/odometry_to_ego_track_transform.sv]
// Top level: odometry-to-ego frame transform of one track vector per transaction.
//
// Fully pipelined: a transaction is taken in every cycle (busy stays low) and
// its result appears on the out_ ports, marked by out_valid for one cycle,
// after the entry register, the CORDIC cell row for the ego heading's cosine
// and sine, the P0 to P4 registers, the square-root cell row (one result bit
// per cell) and the output register. The receiver cannot stall; results must
// be taken when shown. Ego pose registers are to be written through cfg_ only
// while no transaction is in flight; the block itself does not enforce this.
module odometry_to_ego_track_transform
  import o2e_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [(COORD_WIDTH > ANGLE_WIDTH ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_vector_kind,
  input  logic signed [COORD_WIDTH-1:0]         in_comp_x,
  input  logic signed [COORD_WIDTH-1:0]         in_comp_y,
  input  logic [COORD_WIDTH-1:0]                in_dev_x,
  input  logic [COORD_WIDTH-1:0]                in_dev_y,
  input  logic signed [ANGLE_WIDTH-1:0]         in_heading,
  output logic                                  out_valid,
  output logic signed [COORD_WIDTH-1:0]         out_x,
  output logic signed [COORD_WIDTH-1:0]         out_y,
  output logic [COORD_WIDTH-1:0]                out_dev_x,
  output logic [COORD_WIDTH-1:0]                out_dev_y,
  output logic signed [ANGLE_WIDTH-1:0]         out_heading,
  output logic                                  out_clipped
);

  localparam int CW     = COORD_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int TS     = TRIG_STAGES;
  localparam int DW     = CW + 1;
  localparam int TW     = TRIG_FRAC + 1;
  localparam int PW     = TW + DW;
  localparam int QW     = TW + CW;
  localparam int SW     = CW + 3;
  localparam int SQ_W   = 2 * DW;
  localparam int RAD_W  = 2 * CW + 4;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CPAY_W = 2 * DW + 2 * CW + AW;
  localparam int RPAY_W = 2 * CW + AW + 1;

  localparam logic signed [CORD_W-1:0] TRIG_ONE = CORD_W'(64'sd1 <<< TRIG_FRAC);
  localparam logic signed [CORD_W-1:0] X_INIT   = CORD_W'(CORDIC_INIT);
  localparam logic [PW:0]              HALF_P   = (PW+1)'(64'd1 << (TRIG_FRAC - 1));
  localparam logic [QW:0]              HALF_Q   = (QW+1)'(64'd1 << (TRIG_FRAC - 1));
  localparam logic signed [SW-1:0]     SAT_HI   = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0]     SAT_LO   = -SAT_HI - SW'(1);

  // configuration
  logic signed [CW-1:0] ego_x_r, ego_y_r;
  logic [AW-1:0]        ego_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ego_x_r <= '0;
      ego_y_r <= '0;
      ego_h_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EGO_X:       ego_x_r <= cfg_data[CW-1:0];
        REG_EGO_Y:       ego_y_r <= cfg_data[CW-1:0];
        REG_EGO_HEADING: ego_h_r <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // entry stage
  logic                     acc;
  logic signed [DW-1:0]     ext_x, ext_y, dx_nxt, dy_nxt;
  logic [ANG_FULL_W-1:0]    u_full;
  logic                     flip_nxt;
  logic [ANG_FULL_W-1:0]    u_fold;
  logic [AW-1:0]            hd_nxt;

  always_comb begin
    acc      = start && !busy;
    ext_x    = {in_comp_x[CW-1], in_comp_x};
    ext_y    = {in_comp_y[CW-1], in_comp_y};
    if (in_vector_kind == KIND_POSITION) begin
      dx_nxt = ext_x - {ego_x_r[CW-1], ego_x_r};
      dy_nxt = ext_y - {ego_y_r[CW-1], ego_y_r};
    end else begin
      dx_nxt = ext_x;
      dy_nxt = ext_y;
    end
    u_full   = {ego_h_r, {(ANG_FULL_W-AW){1'b0}}};
    flip_nxt = u_full[ANG_FULL_W-1] ^ u_full[ANG_FULL_W-2];
    u_fold   = {u_full[ANG_FULL_W-1] ^ flip_nxt, u_full[ANG_FULL_W-2:0]};
    hd_nxt   = in_heading - ego_h_r;
  end

  logic                     c_vld  [0:TS];
  logic signed [CORD_W-1:0] c_x    [0:TS];
  logic signed [CORD_W-1:0] c_y    [0:TS];
  logic signed [CORD_W-1:0] c_z    [0:TS];
  logic                     c_flip [0:TS];
  logic [CPAY_W-1:0]        c_pay  [0:TS];

  logic                     e_vld_r;
  logic signed [CORD_W-1:0] e_z_r;
  logic                     e_flip_r;
  logic [CPAY_W-1:0]        e_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    e_z_r    <= {u_fold[ANG_FULL_W-1], u_fold};
    e_flip_r <= flip_nxt;
    e_pay_r  <= {dx_nxt, dy_nxt, in_dev_x, in_dev_y, hd_nxt};
  end

  assign c_vld[0]  = e_vld_r;
  assign c_x[0]    = X_INIT;
  assign c_y[0]    = '0;
  assign c_z[0]    = e_z_r;
  assign c_flip[0] = e_flip_r;
  assign c_pay[0]  = e_pay_r;

  for (genvar i = 0; i < TS; i++) begin : g_cordic
    o2e_cordic_cell #(.STAGE(i), .PAY_W(CPAY_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (c_vld[i]),
      .x_i    (c_x[i]),
      .y_i    (c_y[i]),
      .z_i    (c_z[i]),
      .flip_i (c_flip[i]),
      .pay_i  (c_pay[i]),
      .vld_o  (c_vld[i+1]),
      .x_o    (c_x[i+1]),
      .y_o    (c_y[i+1]),
      .z_o    (c_z[i+1]),
      .flip_o (c_flip[i+1]),
      .pay_o  (c_pay[i+1])
    );
  end

  // P0: clamp trig values, take magnitudes
  logic signed [CORD_W-1:0] xf, yf, cc, sc, cn, sn;
  logic signed [DW-1:0]     t_dx, t_dy, ndx, ndy;
  logic [CW-1:0]            t_sx, t_sy;
  logic [AW-1:0]            t_hd;

  always_comb begin
    xf = c_flip[TS] ? -c_x[TS] : c_x[TS];
    yf = c_flip[TS] ? -c_y[TS] : c_y[TS];
    if (xf > TRIG_ONE) begin
      cc = TRIG_ONE;
    end else if (xf < -TRIG_ONE) begin
      cc = -TRIG_ONE;
    end else begin
      cc = xf;
    end
    if (yf > TRIG_ONE) begin
      sc = TRIG_ONE;
    end else if (yf < -TRIG_ONE) begin
      sc = -TRIG_ONE;
    end else begin
      sc = yf;
    end
    cn = -cc;
    sn = -sc;
    {t_dx, t_dy, t_sx, t_sy, t_hd} = c_pay[TS];
    ndx = -t_dx;
    ndy = -t_dy;
  end

  logic          p0_vld_r;
  logic [TW-1:0] p0_cm_r, p0_sm_r;
  logic          p0_cn_r, p0_sn_r, p0_xn_r, p0_yn_r;
  logic [DW-1:0] p0_xm_r, p0_ym_r;
  logic [CW-1:0] p0_sx_r, p0_sy_r;
  logic [AW-1:0] p0_hd_r;

  always_ff @(posedge clk) begin
    p0_cm_r <= cc[CORD_W-1] ? cn[TW-1:0] : cc[TW-1:0];
    p0_sm_r <= sc[CORD_W-1] ? sn[TW-1:0] : sc[TW-1:0];
    p0_cn_r <= cc[CORD_W-1];
    p0_sn_r <= sc[CORD_W-1];
    p0_xn_r <= t_dx[DW-1];
    p0_yn_r <= t_dy[DW-1];
    p0_xm_r <= t_dx[DW-1] ? ndx : t_dx;
    p0_ym_r <= t_dy[DW-1] ? ndy : t_dy;
    p0_sx_r <= t_sx;
    p0_sy_r <= t_sy;
    p0_hd_r <= t_hd;
  end

  // P1: products
  logic          p1_vld_r;
  logic [PW-1:0] p1_cx_r, p1_sy_r, p1_cy_r, p1_sx_r;
  logic          p1_ncx_r, p1_nsy_r, p1_ncy_r, p1_nsx_r;
  logic [QW-1:0] p1_q1_r, p1_q2_r, p1_q3_r, p1_q4_r;
  logic [AW-1:0] p1_hd_r;

  always_ff @(posedge clk) begin
    p1_cx_r  <= PW'(p0_cm_r) * PW'(p0_xm_r);
    p1_sy_r  <= PW'(p0_sm_r) * PW'(p0_ym_r);
    p1_cy_r  <= PW'(p0_cm_r) * PW'(p0_ym_r);
    p1_sx_r  <= PW'(p0_sm_r) * PW'(p0_xm_r);
    p1_ncx_r <= p0_cn_r ^ p0_xn_r;
    p1_nsy_r <= p0_sn_r ^ p0_yn_r;
    p1_ncy_r <= p0_cn_r ^ p0_yn_r;
    p1_nsx_r <= p0_sn_r ^ p0_xn_r;
    p1_q1_r  <= QW'(p0_cm_r) * QW'(p0_sx_r);
    p1_q2_r  <= QW'(p0_sm_r) * QW'(p0_sy_r);
    p1_q3_r  <= QW'(p0_sm_r) * QW'(p0_sx_r);
    p1_q4_r  <= QW'(p0_cm_r) * QW'(p0_sy_r);
    p1_hd_r  <= p0_hd_r;
  end

  // P2: round to Q16.16, combine
  logic [PW:0]          rp_cx, rp_sy, rp_cy, rp_sx;
  logic signed [SW-1:0] m_cx, m_sy, m_cy, m_sx, s_cx, s_sy, s_cy, s_sx;
  logic [QW:0]          rq1, rq2, rq3, rq4;

  always_comb begin
    rp_cx = {1'b0, p1_cx_r} + HALF_P;
    rp_sy = {1'b0, p1_sy_r} + HALF_P;
    rp_cy = {1'b0, p1_cy_r} + HALF_P;
    rp_sx = {1'b0, p1_sx_r} + HALF_P;
    m_cx  = SW'(rp_cx[TRIG_FRAC +: DW]);
    m_sy  = SW'(rp_sy[TRIG_FRAC +: DW]);
    m_cy  = SW'(rp_cy[TRIG_FRAC +: DW]);
    m_sx  = SW'(rp_sx[TRIG_FRAC +: DW]);
    s_cx  = p1_ncx_r ? -m_cx : m_cx;
    s_sy  = p1_nsy_r ? -m_sy : m_sy;
    s_cy  = p1_ncy_r ? -m_cy : m_cy;
    s_sx  = p1_nsx_r ? -m_sx : m_sx;
    rq1   = {1'b0, p1_q1_r} + HALF_Q;
    rq2   = {1'b0, p1_q2_r} + HALF_Q;
    rq3   = {1'b0, p1_q3_r} + HALF_Q;
    rq4   = {1'b0, p1_q4_r} + HALF_Q;
  end

  logic                 p2_vld_r;
  logic signed [SW-1:0] p2_ox_r, p2_oy_r;
  logic [DW-1:0]        p2_d1_r, p2_d2_r, p2_d3_r, p2_d4_r;
  logic [AW-1:0]        p2_hd_r;

  always_ff @(posedge clk) begin
    p2_ox_r <= s_cx + s_sy;
    p2_oy_r <= s_cy - s_sx;
    p2_d1_r <= rq1[TRIG_FRAC +: DW];
    p2_d2_r <= rq2[TRIG_FRAC +: DW];
    p2_d3_r <= rq3[TRIG_FRAC +: DW];
    p2_d4_r <= rq4[TRIG_FRAC +: DW];
    p2_hd_r <= p1_hd_r;
  end

  // P3: saturate coordinates, square deviations
  logic [CW-1:0] sat_x, sat_y;
  logic          clip_xy;

  always_comb begin
    clip_xy = 1'b0;
    if (p2_ox_r > SAT_HI) begin
      sat_x   = SAT_HI[CW-1:0];
      clip_xy = 1'b1;
    end else if (p2_ox_r < SAT_LO) begin
      sat_x   = SAT_LO[CW-1:0];
      clip_xy = 1'b1;
    end else begin
      sat_x = p2_ox_r[CW-1:0];
    end
    if (p2_oy_r > SAT_HI) begin
      sat_y   = SAT_HI[CW-1:0];
      clip_xy = 1'b1;
    end else if (p2_oy_r < SAT_LO) begin
      sat_y   = SAT_LO[CW-1:0];
      clip_xy = 1'b1;
    end else begin
      sat_y = p2_oy_r[CW-1:0];
    end
  end

  logic            p3_vld_r;
  logic [SQ_W-1:0] p3_sq1_r, p3_sq2_r, p3_sq3_r, p3_sq4_r;
  logic [RPAY_W-1:0] p3_pay_r;

  always_ff @(posedge clk) begin
    p3_sq1_r <= SQ_W'(p2_d1_r) * SQ_W'(p2_d1_r);
    p3_sq2_r <= SQ_W'(p2_d2_r) * SQ_W'(p2_d2_r);
    p3_sq3_r <= SQ_W'(p2_d3_r) * SQ_W'(p2_d3_r);
    p3_sq4_r <= SQ_W'(p2_d4_r) * SQ_W'(p2_d4_r);
    p3_pay_r <= {sat_x, sat_y, p2_hd_r, clip_xy};
  end

  // P4: sums of squares
  logic              p4_vld_r;
  logic [RAD_W-1:0]  p4_ra_r, p4_rb_r;
  logic [RPAY_W-1:0] p4_pay_r;

  always_ff @(posedge clk) begin
    p4_ra_r  <= RAD_W'(p3_sq1_r) + RAD_W'(p3_sq2_r);
    p4_rb_r  <= RAD_W'(p3_sq3_r) + RAD_W'(p3_sq4_r);
    p4_pay_r <= p3_pay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= c_vld[TS];
      p1_vld_r <= p0_vld_r;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
    end
  end

  // square-root cell row
  logic              r_vld    [0:ROOT_W];
  logic [RAD_W-1:0]  r_rad_a  [0:ROOT_W];
  logic [REM_W-1:0]  r_rem_a  [0:ROOT_W];
  logic [ROOT_W-1:0] r_root_a [0:ROOT_W];
  logic [RAD_W-1:0]  r_rad_b  [0:ROOT_W];
  logic [REM_W-1:0]  r_rem_b  [0:ROOT_W];
  logic [ROOT_W-1:0] r_root_b [0:ROOT_W];
  logic [RPAY_W-1:0] r_pay    [0:ROOT_W];

  assign r_vld[0]    = p4_vld_r;
  assign r_rad_a[0]  = p4_ra_r;
  assign r_rem_a[0]  = '0;
  assign r_root_a[0] = '0;
  assign r_rad_b[0]  = p4_rb_r;
  assign r_rem_b[0]  = '0;
  assign r_root_b[0] = '0;
  assign r_pay[0]    = p4_pay_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    o2e_root_cell #(.RAD_W(RAD_W), .PAY_W(RPAY_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .vld_i    (r_vld[k]),
      .rad_a_i  (r_rad_a[k]),
      .rem_a_i  (r_rem_a[k]),
      .root_a_i (r_root_a[k]),
      .rad_b_i  (r_rad_b[k]),
      .rem_b_i  (r_rem_b[k]),
      .root_b_i (r_root_b[k]),
      .pay_i    (r_pay[k]),
      .vld_o    (r_vld[k+1]),
      .rad_a_o  (r_rad_a[k+1]),
      .rem_a_o  (r_rem_a[k+1]),
      .root_a_o (r_root_a[k+1]),
      .rad_b_o  (r_rad_b[k+1]),
      .rem_b_o  (r_rem_b[k+1]),
      .root_b_o (r_root_b[k+1]),
      .pay_o    (r_pay[k+1])
    );
  end

  // output register
  logic              ovf_a, ovf_b;
  logic [CW-1:0]     f_x, f_y;
  logic [AW-1:0]     f_hd;
  logic              f_clip;
  logic              out_valid_r, out_clipped_r;
  logic [CW-1:0]     out_x_r, out_y_r, out_dev_x_r, out_dev_y_r;
  logic [AW-1:0]     out_heading_r;

  always_comb begin
    ovf_a = |r_root_a[ROOT_W][ROOT_W-1:CW];
    ovf_b = |r_root_b[ROOT_W][ROOT_W-1:CW];
    {f_x, f_y, f_hd, f_clip} = r_pay[ROOT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= r_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    out_x_r       <= f_x;
    out_y_r       <= f_y;
    out_dev_x_r   <= ovf_a ? {CW{1'b1}} : r_root_a[ROOT_W][CW-1:0];
    out_dev_y_r   <= ovf_b ? {CW{1'b1}} : r_root_b[ROOT_W][CW-1:0];
    out_heading_r <= f_hd;
    out_clipped_r <= f_clip | ovf_a | ovf_b;
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_dev_x   = out_dev_x_r;
  assign out_dev_y   = out_dev_y_r;
  assign out_heading = out_heading_r;
  assign out_clipped = out_clipped_r;

endmodule
